>>> hdl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_WAIT = 4'b0001,
    PH_BODY = 4'b0010,
    PH_ESC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_e;

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       last;
  } result_t;

  // character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;

  // utf-8 range limits and prefixes
  localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
  localparam logic [2:0]  LEAD2_PREFIX = 3'b110;
  localparam logic [3:0]  LEAD3_PREFIX = 4'b1110;
  localparam logic [1:0]  CONT_PREFIX  = 2'b10;

  // output buffer depth: one waiting word plus the largest burst of three
  localparam int unsigned BUF_DEPTH = 4;
  localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int unsigned MAX_RES = 3;

  // hex digit decode, valid flag in bit 4 low means a digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  // single-character escape map
  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      CH_B:    m = 8'h08;
      CH_F:    m = 8'h0C;
      CH_N:    m = 8'h0A;
      CH_R:    m = 8'h0D;
      CH_T:    m = 8'h09;
      default: m = c;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hdl/jsu_if.sv
`default_nettype none

// raw text channel
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       input_end;

  modport source (output valid, output in_byte, output input_end, input ready);
  modport sink (input valid, input in_byte, input input_end, output ready);
endinterface

// decoded result channel
interface jsu_out_if import jsu_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  kind_e      kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/json_string_unescape.sv
`default_nettype none
// Results of an accepted byte enter the registered output buffer and leave from its head.
// Throughput: one input word per cycle while each word yields at most one result and the
// output is ready. A fourth hex digit of a \u escape yields up to three words, drained one
// per cycle while the output is ready from a four-entry buffer; input is ready while at most
// one word is waiting. Reset clears the phase, hex count, code point and buffer fill count.

module json_string_unescape import jsu_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  jsu_in_if.sink       in_i,
  jsu_out_if.source    out_o
);

  phase_e        phase_q, phase_d;
  logic [1:0]    hc_q, hc_d;
  logic [15:0]   cp_q, cp_d;
  result_t       buf_q [BUF_DEPTH];
  result_t       buf_d [BUF_DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_pop;

  result_t       res [MAX_RES];
  logic [1:0]    nres;
  logic          in_fire, out_fire;
  logic [4:0]    hv;
  logic [15:0]   cp_new;
  logic [7:0]    c;

  assign in_i.ready = (cnt_q <= CNT_W'(1));
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  assign c      = in_i.in_byte;
  assign hv     = hex_value(c);
  assign cp_new = {cp_q[11:0], hv[3:0]};

  // decode one input word into up to three results
  always_comb begin
    phase_d = phase_q;
    hc_d    = hc_q;
    cp_d    = cp_q;
    nres    = 2'd0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '{out_byte: 8'h00, kind: KIND_BYTE, last: 1'b1};
    end
    if (in_i.input_end) begin
      phase_d = PH_WAIT;
      hc_d    = 2'd0;
      cp_d    = 16'h0000;
      nres    = 2'd1;
      res[0].kind = KIND_ERROR;
    end else begin
      unique case (phase_q)
        PH_WAIT: begin
          if (c == CH_QUOTE) begin
            phase_d = PH_BODY;
          end else begin
            hc_d = 2'd0;
            cp_d = 16'h0000;
            nres = 2'd1;
            res[0].kind = KIND_ERROR;
          end
        end
        PH_BODY: begin
          if (c == CH_QUOTE) begin
            phase_d = PH_WAIT;
            nres    = 2'd1;
            res[0].kind = KIND_CLOSE;
          end else if (c == CH_BSLASH) begin
            phase_d = PH_ESC;
          end else begin
            nres = 2'd1;
            res[0].out_byte = c;
          end
        end
        PH_ESC: begin
          if (c == CH_U) begin
            phase_d = PH_HEX;
            hc_d    = 2'd0;
            cp_d    = 16'h0000;
          end else begin
            phase_d = PH_BODY;
            nres    = 2'd1;
            res[0].out_byte = map_escape(c);
          end
        end
        PH_HEX: begin
          if (hv[4]) begin
            phase_d = PH_WAIT;
            hc_d    = 2'd0;
            cp_d    = 16'h0000;
            nres    = 2'd1;
            res[0].kind = KIND_ERROR;
          end else if (hc_q != 2'd3) begin
            hc_d = hc_q + 2'd1;
            cp_d = cp_new;
          end else begin
            phase_d = PH_BODY;
            hc_d    = 2'd0;
            cp_d    = 16'h0000;
            // utf-8 encode
            if (cp_new < CP_ONE_LIMIT) begin
              nres = 2'd1;
              res[0].out_byte = cp_new[7:0];
            end else if (cp_new < CP_TWO_LIMIT) begin
              nres = 2'd2;
              res[0].out_byte = {LEAD2_PREFIX, cp_new[10:6]};
              res[0].last     = 1'b0;
              res[1].out_byte = {CONT_PREFIX, cp_new[5:0]};
            end else begin
              nres = 2'd3;
              res[0].out_byte = {LEAD3_PREFIX, cp_new[15:12]};
              res[0].last     = 1'b0;
              res[1].out_byte = {CONT_PREFIX, cp_new[11:6]};
              res[1].last     = 1'b0;
              res[2].out_byte = {CONT_PREFIX, cp_new[5:0]};
            end
          end
        end
        default: begin
          phase_d = PH_WAIT;
        end
      endcase
    end
  end

  // output buffer: shift out at the head, append new words after the survivors
  always_comb begin
    cnt_pop = cnt_q - CNT_W'(out_fire);
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (out_fire && i < BUF_DEPTH - 1) begin
        buf_d[i] = buf_q[i + 1];
      end else begin
        buf_d[i] = buf_q[i];
      end
      for (int k = 0; k < MAX_RES; k++) begin
        if (in_fire && (2'(k) < nres) && (cnt_pop + CNT_W'(k) == CNT_W'(i))) begin
          buf_d[i] = res[k];
        end
      end
    end
    cnt_d = cnt_pop + (in_fire ? CNT_W'(nres) : CNT_W'(0));
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      hc_q    <= 2'd0;
      cp_q    <= 16'h0000;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        phase_q <= phase_d;
        hc_q    <= hc_d;
        cp_q    <= cp_d;
      end
    end
  end

  // buffer payload
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // head of the buffer drives the output word
  assign out_o.valid    = (cnt_q != '0);
  assign out_o.out_byte = buf_q[0].out_byte;
  assign out_o.kind     = buf_q[0].kind;
  assign out_o.last     = buf_q[0].last;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(BUF_DEPTH))
    else $error("output buffer overfilled");

  a_end_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.input_end |=> phase_q == PH_WAIT && hc_q == 2'd0)
    else $error("end of input did not return to waiting");

  a_hex_count_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q != 2'd0 |-> phase_q == PH_HEX)
    else $error("hex count set outside of a hex escape");

  a_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_W'(1) |-> buf_q[0].last)
    else $error("lone buffered word is not the last of its input");

  a_error_empty_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind != KIND_BYTE |-> out_o.out_byte == 8'h00 && out_o.last)
    else $error("close or error word carries data");
`endif

endmodule

`default_nettype wire
